[sv/snd_pkg.sv]
// Shared constants, types and the logistic lookup table for the single neuron unit.
package snd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LUT_DEPTH = 256;
	localparam int LUT_AW    = $clog2(LUT_DEPTH);
	// Index = (sum + 8.0) * LUT_DEPTH / 16.0, taken as a right shift of the offset sum.
	localparam int IDX_SHIFT = FRAC_BITS + 4 - LUT_AW;

	localparam int OPW = 33;        // multiplier operand width
	localparam int PW  = 2 * OPW;   // product width

	localparam logic [1:0] CMD_EVAL  = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic REG_UNIT_MODE  = 1'b0;
	localparam logic REG_LEARN_RATE = 1'b1;

	localparam logic MODE_LINEAR  = 1'b0;
	localparam logic MODE_SIGMOID = 1'b1;

	typedef logic signed [OPW-1:0] opnd_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic [63:0]           u64_t;
	typedef logic [31:0]           lut_t [LUT_DEPTH];

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input prod_t v);
		prod_t hi;
		prod_t lo;
		hi = PW'(33'sh0_7FFF_FFFF);
		lo = PW'(-33'sh0_8000_0000);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Unsigned quotient by shift and subtract; only evaluated while the table is built.
	function automatic u64_t udiv64(input u64_t n, input u64_t d);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int j = 63; j >= 0; j--) begin
			r = {r[62:0], n[j]};
			if (r >= d) begin
				r = r - d;
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// Logistic over [-8,8): exp(-|x|) as (exp(-|x|/16))^16 from a Taylor series in Q31.
	function automatic lut_t build_lut();
		lut_t   r;
		longint num;
		longint t;
		longint term;
		longint acc;
		u64_t   mag;
		u64_t   z;
		u64_t   den;
		u64_t   val;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			num = 64'(16) * longint'(i) - 64'(8) * longint'(LUT_DEPTH);
			mag = (num < 0) ? u64_t'(-num) : u64_t'(num);
			t = longint'(udiv64(mag << 27, u64_t'(LUT_DEPTH)));
			term = longint'(64'd1 << 31);
			acc = term;
			for (int k = 1; k <= 14; k++) begin
				// terms stay non-negative, so an unsigned quotient matches truncation
				term = (term * t) >>> 31;
				term = longint'(udiv64(u64_t'(term), u64_t'(k)));
				if (k[0] == 1'b1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			z = (acc < 0) ? 64'd0 : u64_t'(acc);
			for (int k = 0; k < 4; k++) begin
				z = (z * z + (64'd1 << 30)) >> 31;
			end
			den = (64'd1 << 31) + z;
			if (num >= 0) begin
				val = udiv64((64'd1 << (FRAC_BITS + 31)) + (den >> 1), den);
			end else begin
				val = udiv64((z << FRAC_BITS) + (den >> 1), den);
			end
			r[i] = val[31:0];
		end
		return r;
	endfunction

	localparam lut_t LOGISTIC_LUT = build_lut();

endpackage

[sv/snd_mul.sv]
// Shared signed multiplier with a registered product.
module snd_mul
	import snd_pkg::*;
(
	input  logic  clk,
	input  opnd_t a,
	input  opnd_t b,
	output prod_t p
);

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= PW'(a) * PW'(b);
	end

	assign p = p_q;

endmodule

[sv/single_neuron_delta_rule.sv]
// Single neuron (bias plus two weights) with evaluate, delta-rule train and weight write.
// One signed 33x33 multiplier with a registered product is shared by every multiplication, and a
// one-hot sequencer feeds it. An item is transferred only while the sequencer is idle.
// Evaluate steps through EV1 to EV4 (two products, the sum, then the table or threshold
// stage) and holds in EV4 until the output register is free; the result goes to that
// register, so the next item may enter while it waits. Train steps through TR1, TR2,
// TR5 to TR7; sigmoid mode adds TR3 and TR4 to scale the step by the derivative. A
// weight write completes on transfer. Configuration registers sit at byte address 0
// (unit_mode) and 4 (learn_rate); only address bit 2 is decoded.
module single_neuron_delta_rule
	import snd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // feature_a, feature_b, target, activation_in, weight_value
	input  logic [3:0]   s_tuser,  // command, weight_index
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // activation
	output logic [0:0]   m_tuser   // classified
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_EV1  = 12'b0000_0000_0010,
		S_EV2  = 12'b0000_0000_0100,
		S_EV3  = 12'b0000_0000_1000,
		S_EV4  = 12'b0000_0001_0000,
		S_TR1  = 12'b0000_0010_0000,
		S_TR2  = 12'b0000_0100_0000,
		S_TR3  = 12'b0000_1000_0000,
		S_TR4  = 12'b0001_0000_0000,
		S_TR5  = 12'b0010_0000_0000,
		S_TR6  = 12'b0100_0000_0000,
		S_TR7  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic        unit_mode_q;
	logic [15:0] learn_rate_q;

	logic signed [31:0] w_q [3];
	logic signed [31:0] fa_q;
	logic signed [31:0] fb_q;
	logic signed [31:0] tgt_q;
	logic signed [31:0] act_q;
	logic signed [31:0] fac_q;
	prod_t              acc_q;
	logic signed [31:0] sum_q;

	logic               m_tvalid_q;
	logic [31:0]        act_out_q;
	logic               cls_q;

	opnd_t mul_a;
	opnd_t mul_b;
	prod_t prod;
	prod_t prod_sh;

	logic               in_xfer;
	logic               cfg_wr;
	logic [1:0]         cmd;
	logic [1:0]         widx;
	logic signed [31:0] err;
	logic signed [31:0] der;
	logic               out_free;

	logic signed [32:0] sum_off;
	logic [LUT_AW-1:0]  lut_idx;
	logic signed [31:0] eval_act;
	logic               eval_cls;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign prdata   = (paddr[2] == REG_LEARN_RATE) ? {16'b0, learn_rate_q}
	                                                : {31'b0, unit_mode_q};

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid & s_tready;
	assign cmd      = s_tuser[1:0];
	assign widx     = s_tuser[3:2];

	assign out_free = ~m_tvalid_q | m_tready;

	assign prod_sh  = prod >>> FRAC_BITS;
	assign err      = sat32(PW'(tgt_q) - PW'(act_q));
	assign der      = sat32(prod_sh);

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_EV1: begin
				mul_a = OPW'(w_q[1]);
				mul_b = OPW'(fa_q);
			end
			S_EV2: begin
				mul_a = OPW'(w_q[2]);
				mul_b = OPW'(fb_q);
			end
			S_TR1: begin
				mul_a = OPW'(err);
				mul_b = {17'b0, learn_rate_q};
			end
			S_TR2: begin
				mul_a = OPW'(act_q);
				mul_b = OPW'(33'sd1 <<< FRAC_BITS) - OPW'(act_q);
			end
			S_TR3: begin
				mul_a = OPW'(fac_q);
				mul_b = OPW'(der);
			end
			S_TR5: begin
				mul_a = OPW'(fac_q);
				mul_b = OPW'(fa_q);
			end
			S_TR6: begin
				mul_a = OPW'(fac_q);
				mul_b = OPW'(fb_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	snd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Table index with clamping at both ends of [-8,8)
	assign sum_off = 33'(sum_q) + 33'(33'sd8 <<< FRAC_BITS);

	always_comb begin
		if (sum_off < 0) begin
			lut_idx = '0;
		end else if (sum_off >= (33'sd16 <<< FRAC_BITS)) begin
			lut_idx = LUT_AW'(LUT_DEPTH - 1);
		end else begin
			lut_idx = sum_off[IDX_SHIFT +: LUT_AW];
		end
	end

	always_comb begin
		if (unit_mode_q == MODE_SIGMOID) begin
			eval_act = LOGISTIC_LUT[lut_idx];
			eval_cls = (eval_act > (32'sd1 <<< (FRAC_BITS - 1)));
		end else begin
			eval_act = sum_q;
			eval_cls = (sum_q > 32'sd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q  <= MODE_LINEAR;
			learn_rate_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_UNIT_MODE:  unit_mode_q  <= pwdata[0];
				REG_LEARN_RATE: learn_rate_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q[0]  <= '0;
			w_q[1]  <= '0;
			w_q[2]  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (cmd)
							CMD_EVAL:  state_q <= S_EV1;
							CMD_TRAIN: state_q <= S_TR1;
							CMD_WRITE: begin
								if (widx != 2'd3) begin
									w_q[widx] <= s_tdata[159:128];
								end
							end
							default: ;
						endcase
					end
				end
				S_EV1: state_q <= S_EV2;
				S_EV2: state_q <= S_EV3;
				S_EV3: state_q <= S_EV4;
				S_EV4: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TR1: state_q <= S_TR2;
				S_TR2: state_q <= (unit_mode_q == MODE_SIGMOID) ? S_TR3 : S_TR5;
				S_TR3: state_q <= S_TR4;
				S_TR4: state_q <= S_TR5;
				S_TR5: begin
					w_q[0]  <= sat32(PW'(w_q[0]) + PW'(fac_q));
					state_q <= S_TR6;
				end
				S_TR6: begin
					w_q[1]  <= sat32(PW'(w_q[1]) + PW'(sat32(prod_sh)));
					state_q <= S_TR7;
				end
				S_TR7: begin
					w_q[2]  <= sat32(PW'(w_q[2]) + PW'(sat32(prod_sh)));
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand and intermediate registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fa_q  <= s_tdata[31:0];
			fb_q  <= s_tdata[63:32];
			tgt_q <= s_tdata[95:64];
			act_q <= s_tdata[127:96];
		end
		case (state_q)
			S_EV2: acc_q <= PW'(w_q[0]) + prod_sh;
			S_EV3: sum_q <= sat32(acc_q + prod_sh);
			S_TR2: fac_q <= prod_sh[31:0];
			S_TR4: fac_q <= sat32(prod_sh);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_EV4 && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EV4 && out_free) begin
			act_out_q <= eval_act;
			cls_q     <= eval_cls;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = act_out_q;
	assign m_tuser[0] = cls_q;

endmodule

[tb/single_neuron_delta_rule_checker.sv]
// Checker for the single neuron unit: tracks weights and registers, predicts results, compares.
`timescale 1ns / 100ps
module single_neuron_delta_rule_checker
	import snd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,  // feature_a, feature_b, target, activation_in, weight_value
	input  logic [3:0]   s_tuser,  // command, weight_index
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,  // activation
	input  logic [0:0]   m_tuser,  // classified
	output int           mismatch_count,
	output int           results_owed
);

	localparam int BIAS         = 0;
	localparam int WEIGHT_A     = 1;
	localparam int WEIGHT_B     = 2;
	localparam int WEIGHT_COUNT = 3;
	localparam int RATE_BITS    = 16;
	localparam int MAX_PRINTED  = 100;

	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] activation;
		logic               classified;
	} neuron_output_t;

	neuron_output_t     owed_outputs [$];
	logic signed [31:0] weight_reg [WEIGHT_COUNT];
	logic signed [31:0] logistic_rom [LUT_DEPTH];
	logic               unit_mode_q;
	logic [15:0]        learn_rate_q;

	initial mismatch_count = 0;
	initial results_owed = 0;

	function automatic longint clamp32(input longint v);
		if (v > S32_HI) return S32_HI;
		if (v < S32_LO) return S32_LO;
		return v;
	endfunction

	// Logistic over [-8,8): exp(-|x|) is the 16th power of a Taylor series for exp(-|x|/16).
	function automatic void fill_logistic_rom();
		longint          num;
		longint          t;
		longint          term;
		longint          acc;
		longint unsigned mag;
		longint unsigned z;
		longint unsigned den;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			num = longint'(16 * i) - longint'(8 * LUT_DEPTH);
			mag = (num < 0) ? -num : num;
			t = longint'((mag << 27) / LUT_DEPTH);
			term = longint'(1) << 31;
			acc = term;
			for (int k = 1; k <= 14; k++) begin
				term = (term * t) >>> 31;
				term = term / k;
				acc = (k % 2 == 1) ? acc - term : acc + term;
			end
			z = (acc < 0) ? 64'd0 : acc;
			repeat (4) z = (z * z + (64'd1 << 30)) >> 31;
			den = (64'd1 << 31) + z;
			if (num >= 0) begin
				logistic_rom[i] = 32'(((64'd1 << (FRAC_BITS + 31)) + den / 2) / den);
			end else begin
				logistic_rom[i] = 32'(((z << FRAC_BITS) + den / 2) / den);
			end
		end
	endfunction

	initial fill_logistic_rom();

	function automatic neuron_output_t evaluate_neuron(input logic signed [31:0] fa,
		input logic signed [31:0] fb);
		longint         total;
		longint         offset;
		int             idx;
		neuron_output_t r;
		total = clamp32(longint'(weight_reg[BIAS])
			+ ((longint'(weight_reg[WEIGHT_A]) * longint'(fa)) >>> FRAC_BITS)
			+ ((longint'(weight_reg[WEIGHT_B]) * longint'(fb)) >>> FRAC_BITS));
		if (unit_mode_q == MODE_LINEAR) begin
			r.activation = 32'(total);
			r.classified = (total > 0);
		end else begin
			// table index from the sum shifted up by 8.0, clamped at both ends
			offset = total + (longint'(8) << FRAC_BITS);
			if (offset < 0) begin
				idx = 0;
			end else if (offset >= (longint'(16) << FRAC_BITS)) begin
				idx = LUT_DEPTH - 1;
			end else begin
				idx = int'((offset * LUT_DEPTH) >>> (FRAC_BITS + 4));
			end
			r.activation = logistic_rom[idx];
			r.classified = (logistic_rom[idx] > (32'sd1 <<< (FRAC_BITS - 1)));
		end
		return r;
	endfunction

	function automatic void train_neuron(input logic signed [31:0] tgt, actv, fa, fb);
		longint err;
		longint step;
		longint slope;
		err = clamp32(longint'(tgt) - longint'(actv));
		step = (err * longint'(learn_rate_q)) >>> RATE_BITS;
		if (unit_mode_q == MODE_SIGMOID) begin
			slope = clamp32((longint'(actv) * ((longint'(1) << FRAC_BITS) - longint'(actv)))
				>>> FRAC_BITS);
			step = clamp32((step * slope) >>> FRAC_BITS);
		end
		weight_reg[BIAS] = 32'(clamp32(longint'(weight_reg[BIAS]) + step));
		weight_reg[WEIGHT_A] = 32'(clamp32(longint'(weight_reg[WEIGHT_A])
			+ clamp32((step * longint'(fa)) >>> FRAC_BITS)));
		weight_reg[WEIGHT_B] = 32'(clamp32(longint'(weight_reg[WEIGHT_B])
			+ clamp32((step * longint'(fb)) >>> FRAC_BITS)));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		neuron_output_t want;
		if (!arst_n) begin
			foreach (weight_reg[i]) weight_reg[i] = '0;
			unit_mode_q = MODE_LINEAR;
			learn_rate_q = '0;
			owed_outputs.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LEARN_RATE) begin
					learn_rate_q = pwdata[15:0];
				end else begin
					unit_mode_q = pwdata[0];
				end
			end
			// compare before predicting so a same-edge input never pairs with this output
			if (m_tvalid && m_tready) begin
				if (owed_outputs.size() == 0) begin
					report_mismatch($sformatf("result %h/%b with nothing owed", m_tdata, m_tuser));
				end else begin
					want = owed_outputs.pop_front();
					if (m_tdata !== want.activation) begin
						report_mismatch($sformatf("activation %h, predicted %h",
							m_tdata, want.activation));
					end
					if (m_tuser[0] !== want.classified) begin
						report_mismatch($sformatf("classified %b, predicted %b (activation %h)",
							m_tuser[0], want.classified, want.activation));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser[1:0])
					CMD_EVAL: begin
						owed_outputs.push_back(evaluate_neuron(s_tdata[31:0], s_tdata[63:32]));
					end
					CMD_TRAIN: begin
						train_neuron(s_tdata[95:64], s_tdata[127:96], s_tdata[31:0], s_tdata[63:32]);
					end
					CMD_WRITE: begin
						if (s_tuser[3:2] < WEIGHT_COUNT) begin
							weight_reg[s_tuser[3:2]] = s_tdata[159:128];
						end
					end
					default: ;
				endcase
			end
		end
		results_owed = owed_outputs.size();
	end

endmodule

[tb/single_neuron_delta_rule_tb.sv]
// Top of the single neuron testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps
module single_neuron_delta_rule_tb
	import snd_pkg::*;
;

	localparam logic [1:0]  CMD_NONE        = 2'd3;
	localparam logic [1:0]  W_BIAS          = 2'd0;
	localparam logic [1:0]  W_FEATURE_A     = 2'd1;
	localparam logic [1:0]  W_FEATURE_B     = 2'd2;
	localparam logic [1:0]  W_UNUSED        = 2'd3;
	localparam logic [2:0]  ADDR_UNIT_MODE  = {REG_UNIT_MODE, 2'b00};
	localparam logic [2:0]  ADDR_LEARN_RATE = {REG_LEARN_RATE, 2'b00};
	localparam logic [31:0] Q_ONE           = 32'h0001_0000;
	localparam logic [31:0] Q_HALF          = 32'h0000_8000;
	localparam logic [31:0] Q_EIGHT         = 32'h0008_0000;
	localparam logic [31:0] S32_MAX         = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN         = 32'h8000_0000;
	localparam logic [31:0] FEATURE_SPAN    = 32'h0004_0000;
	localparam logic [31:0] WEIGHT_SPAN     = 32'h0003_0000;
	localparam int          SETTLE_CYCLES   = 16;
	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          PHASES          = 6;
	localparam int          ITEMS_PER_PHASE = 128;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;  // feature_a, feature_b, target, activation_in, weight_value
	logic [3:0]   s_tuser;  // command, weight_index
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;  // activation
	logic [0:0]   m_tuser;  // classified
	int           mismatch_count;
	int           results_owed;

	bit   quiet = 1'b0;
	logic cur_mode = MODE_LINEAR;
	int   idle_cycles = 0;
	int   n_eval = 0;
	int   n_train = 0;
	int   n_write = 0;
	int   n_ignored = 0;
	int   n_settings = 0;

	single_neuron_delta_rule dut (.*);

	single_neuron_delta_rule_checker checker_i (.*);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stop the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("single_neuron_delta_rule_tb NOT OK");
			$finish;
		end
	end

	// Result sink: stall a random number of cycles after each transfer.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [31:0] draw_q16(input logic [31:0] span);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return S32_MAX;
					1: return S32_MIN;
					2: return 32'd0;
					3: return 32'd1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2: return $urandom();
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [1:0] widx,
		input logic [31:0] fa, fb, tgt, actv, wv);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wv, actv, tgt, fb, fa};
		s_tuser <= {widx, cmd};
		do @(posedge clk); while (!s_tready);
		case (cmd)
			CMD_EVAL: n_eval++;
			CMD_TRAIN: n_train++;
			CMD_WRITE: begin
				if (widx == W_UNUSED) n_ignored++;
				else n_write++;
			end
			default: n_ignored++;
		endcase
	endtask

	task automatic issue_evaluate(input logic [31:0] fa, fb);
		send_item(CMD_EVAL, 2'($urandom), fa, fb, $urandom, $urandom, $urandom);
	endtask

	task automatic issue_train(input logic [31:0] tgt, actv, fa, fb);
		send_item(CMD_TRAIN, 2'($urandom), fa, fb, tgt, actv, $urandom);
	endtask

	task automatic issue_write(input logic [1:0] widx, input logic [31:0] value);
		send_item(CMD_WRITE, widx, $urandom, $urandom, $urandom, $urandom, value);
	endtask

	// Hold the sender until every owed result is out, then let trains and writes finish.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input logic mode, input logic [15:0] rate);
		wait_for_results();
		apb_write(ADDR_UNIT_MODE, {31'd0, mode});
		apb_write(ADDR_LEARN_RATE, {16'd0, rate});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_mode = mode;
		n_settings++;
	endtask

	task automatic random_item();
		int unsigned pick;
		logic [1:0]  cmd;
		logic [1:0]  widx;
		logic [31:0] tgt;
		logic [31:0] actv;
		pick = $urandom_range(0, 99);
		if (pick < 45) cmd = CMD_EVAL;
		else if (pick < 75) cmd = CMD_TRAIN;
		else if (pick < 95) cmd = CMD_WRITE;
		else cmd = CMD_NONE;
		widx = ($urandom_range(0, 9) == 0) ? W_UNUSED : 2'($urandom_range(0, 2));
		// mostly class values as targets, some arbitrary
		if ($urandom_range(0, 3) != 0) tgt = $urandom_range(0, 1) ? Q_ONE : 32'd0;
		else tgt = draw_q16(Q_EIGHT);
		// a sigmoid unit output lies in [0,1]; step outside it now and then
		if (cur_mode == MODE_SIGMOID && $urandom_range(0, 4) != 0) actv = $urandom_range(0, Q_ONE);
		else actv = draw_q16(Q_EIGHT);
		send_item(cmd, widx, draw_q16(FEATURE_SPAN), draw_q16(FEATURE_SPAN), tgt, actv,
			draw_q16(WEIGHT_SPAN));
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// linear unit: saturation of the sum both ways, ignored items, training extremes
		set_config(MODE_LINEAR, 16'h8000);
		issue_evaluate(32'd0, 32'd0);
		issue_write(W_BIAS, S32_MAX);
		issue_write(W_FEATURE_A, S32_MAX);
		issue_write(W_FEATURE_B, S32_MAX);
		issue_evaluate(S32_MAX, S32_MAX);
		issue_evaluate(S32_MIN, S32_MIN);
		issue_write(W_UNUSED, 32'd0);
		send_item(CMD_NONE, W_BIAS, $urandom, $urandom, $urandom, $urandom, 32'd0);
		issue_evaluate(32'd0, 32'd0);
		issue_write(W_BIAS, S32_MIN);
		issue_write(W_FEATURE_A, S32_MIN);
		issue_evaluate(S32_MIN, 32'd0);
		issue_train(S32_MAX, S32_MIN, S32_MAX, S32_MIN);
		issue_evaluate(Q_ONE, -Q_ONE);
		issue_train(S32_MIN, S32_MAX, 32'd0, 32'd0);

		// sigmoid unit: both table ends, the half point, derivative extremes
		set_config(MODE_SIGMOID, 16'hFFFF);
		issue_write(W_FEATURE_A, 32'd0);
		issue_write(W_FEATURE_B, 32'd0);
		issue_write(W_BIAS, -Q_EIGHT - 32'd1);
		issue_evaluate(S32_MAX, S32_MIN);
		issue_write(W_BIAS, -Q_EIGHT);
		issue_evaluate(32'd0, 32'd0);
		issue_write(W_BIAS, Q_EIGHT - 32'd1);
		issue_evaluate(32'd0, 32'd0);
		issue_write(W_BIAS, Q_EIGHT);
		issue_evaluate(32'd0, 32'd0);
		issue_write(W_BIAS, 32'd0);
		issue_evaluate(32'd0, 32'd0);
		issue_train(32'd0, S32_MIN, S32_MAX, Q_ONE);
		issue_train(Q_ONE, Q_HALF, Q_ONE, -Q_ONE);
		issue_evaluate(Q_ONE, Q_ONE);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(MODE_LINEAR, 16'($urandom_range(1, 65534)));
				1: set_config(MODE_SIGMOID, 16'hFFFF);
				2: set_config(MODE_LINEAR, 16'h0000);
				3: set_config(MODE_SIGMOID, 16'($urandom));
				4: set_config(MODE_SIGMOID, 16'h0000);
				default: set_config(MODE_LINEAR, 16'hFFFF);
			endcase
			goal = n_eval + n_train + n_write + ITEMS_PER_PHASE;
			while (n_eval + n_train + n_write < goal) begin
				random_item();
				if ($urandom_range(0, 49) == 0) wait_for_results();
				if ($urandom_range(0, 59) == 0) quiet = !quiet;
			end
		end

		wait_for_results();
		$display("Covered %0d evaluates, %0d trains, %0d weight writes, %0d ignored items,",
			n_eval, n_train, n_write, n_ignored);
		$display("under %0d register settings: both unit modes, learning rates 0 up to 65535.",
			n_settings);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("single_neuron_delta_rule_tb OK");
		end else begin
			$display("single_neuron_delta_rule_tb NOT OK");
		end
		$finish;
	end

endmodule
